// ===== rtl/mlp_pkg.sv =====
package mlp_pkg;

    // Network shape
    localparam int IMAGE_PIXELS  = 784;
    localparam int N_NEU         = 10;
    localparam int HIDDEN_LAYERS = 3;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int LAY_W   = 2;
    localparam int NEU_W   = 4;
    localparam int WSEL_W  = 10;
    localparam int COEFF_W = 16;
    localparam int PIX_W   = 8;
    localparam int SCORE_W = 16;
    localparam int POS_W   = 10;

    // Datapath widths
    localparam int ACC_W = 32;
    localparam int ACT_W = 16;
    localparam int CNT_W = NEU_W;

    // Memory geometry
    localparam int W1_DEPTH = N_NEU * IMAGE_PIXELS;
    localparam int W1_AW    = $clog2(W1_DEPTH);
    localparam int W2_DEPTH = HIDDEN_LAYERS * N_NEU * N_NEU;
    localparam int W2_AW    = $clog2(W2_DEPTH);
    localparam int B_DEPTH  = (HIDDEN_LAYERS + 1) * N_NEU;
    localparam int B_AW     = $clog2(B_DEPTH);
    localparam int A_DEPTH  = HIDDEN_LAYERS * N_NEU;
    localparam int A_AW     = $clog2(A_DEPTH);

    // Length of the MAC pipeline drain wait after the last MAC issue
    localparam int MAC_LAT = 2;

    localparam logic [14:0] TANH_TOP = 15'd32746;

    // CMD_RSVD is accepted and ignored
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_W = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_PIXEL  = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [LAY_W-1:0]          layer_sel;
        logic [NEU_W-1:0]          neuron_sel;
        logic [WSEL_W-1:0]         weight_sel;
        logic signed [COEFF_W-1:0] coeff;
        logic [PIX_W-1:0]          pixel;
        logic                      last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [NEU_W-1:0]   class_index;
        logic [SCORE_W-1:0] score;
        logic [NEU_W-1:0]   best_class;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIX,
        S_PIX_WAIT,
        S_NEU,
        S_MAC,
        S_MAC_WAIT,
        S_BIAS_RD,
        S_BIAS_ADD,
        S_ACT1,
        S_ACT2,
        S_ACT3,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             accept;
        logic             pix_mac;
        logic             lay_mac;
        logic             load_sum;
        logic             clr_acc;
        logic             bias_rd;
        logic             bias_add;
        logic             act_s1;
        logic             act_s3;
        logic             clr_sums;
        logic             out_load;
        logic [LAY_W-1:0] layer;
        logic [CNT_W-1:0] y;
        logic [CNT_W-1:0] x;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_pix;
        logic img_end;
        logic out_free;
    } t_dp_status;

    // Saturate a 33-bit sum to the 32-bit accumulator range
    function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] v);
        logic [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    // tanh(k/4) in Q1.15
    function automatic logic [14:0] tanh_tab(input logic [4:0] k);
        logic [14:0] r;
        case (k)
            5'd0:    r = 15'd0;
            5'd1:    r = 15'd8026;
            5'd2:    r = 15'd15143;
            5'd3:    r = 15'd20813;
            5'd4:    r = 15'd24956;
            5'd5:    r = 15'd27797;
            5'd6:    r = 15'd29660;
            5'd7:    r = 15'd30847;
            5'd8:    r = 15'd31589;
            5'd9:    r = 15'd32048;
            5'd10:   r = 15'd32329;
            5'd11:   r = 15'd32500;
            5'd12:   r = 15'd32606;
            5'd13:   r = 15'd32670;
            5'd14:   r = 15'd32708;
            5'd15:   r = 15'd32732;
            default: r = TANH_TOP;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mlp_ram.sv =====
module mlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mlp_ctrl.sv =====
module mlp_ctrl import mlp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_st,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [CNT_W-1:0] LAST_NEU = CNT_W'(N_NEU - 1);
    localparam logic [CNT_W-1:0] LAST_LAT = CNT_W'(MAC_LAT - 1);
    localparam logic [LAY_W-1:0] OUT_LAY  = LAY_W'(HIDDEN_LAYERS);

    t_state           r_state, n_state;
    logic [LAY_W-1:0] r_layer, n_layer;
    logic [CNT_W-1:0] r_y, n_y;
    logic [CNT_W-1:0] r_x, n_x;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_layer <= '0;
            r_y     <= '0;
            r_x     <= '0;
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_y     <= n_y;
            r_x     <= n_x;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_layer     = r_layer;
        n_y         = r_y;
        n_x         = r_x;
        o_cmd       = '0;
        o_cmd.layer = r_layer;
        o_cmd.y     = r_y;
        o_cmd.x     = r_x;
        o_in_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.in_pix) begin
                        n_state = S_PIX;
                        n_y     = '0;
                    end
                end
            end
            S_PIX: begin
                o_cmd.pix_mac = 1'b1;
                if (r_y == LAST_NEU) begin
                    n_y     = '0;
                    n_x     = '0;
                    n_state = S_PIX_WAIT;
                end else begin
                    n_y = r_y + 1'b1;
                end
            end
            S_PIX_WAIT: begin
                if (r_x == LAST_LAT) begin
                    n_x     = '0;
                    n_layer = '0;
                    n_y     = '0;
                    n_state = i_st.img_end ? S_NEU : S_IDLE;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            S_NEU: begin
                if (r_layer == '0) begin
                    o_cmd.load_sum = 1'b1;
                    n_state        = S_BIAS_RD;
                end else begin
                    o_cmd.clr_acc = 1'b1;
                    n_x           = '0;
                    n_state       = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.lay_mac = 1'b1;
                if (r_x == LAST_NEU) begin
                    n_x     = '0;
                    n_state = S_MAC_WAIT;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            S_MAC_WAIT: begin
                if (r_x == LAST_LAT) begin
                    n_x     = '0;
                    n_state = S_BIAS_RD;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            S_BIAS_RD: begin
                o_cmd.bias_rd = 1'b1;
                n_state       = S_BIAS_ADD;
            end
            S_BIAS_ADD: begin
                o_cmd.bias_add = 1'b1;
                n_state        = S_ACT1;
            end
            S_ACT1: begin
                o_cmd.act_s1 = 1'b1;
                n_state      = S_ACT2;
            end
            S_ACT2: begin
                n_state = S_ACT3;
            end
            S_ACT3: begin
                o_cmd.act_s3 = 1'b1;
                if (r_y == LAST_NEU) begin
                    n_y = '0;
                    if (r_layer == '0) begin
                        o_cmd.clr_sums = 1'b1;
                    end
                    if (r_layer == OUT_LAY) begin
                        n_state = S_EMIT;
                    end else begin
                        n_layer = r_layer + 1'b1;
                        n_state = S_NEU;
                    end
                end else begin
                    n_y     = r_y + 1'b1;
                    n_state = S_NEU;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_y == LAST_NEU) begin
                        n_y     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_y = r_y + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mlp_dpath.sv =====
module mlp_dpath import mlp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_st,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out
);

    localparam logic [LAY_W-1:0] OUT_LAY = LAY_W'(HIDDEN_LAYERS);

    // Memory ports
    logic               w1_we, w2_we, b_we, a_we;
    logic [W1_AW-1:0]   w1_addr;
    logic [W2_AW-1:0]   w2_addr;
    logic [B_AW-1:0]    b_addr;
    logic [A_AW-1:0]    a_addr;
    logic [ACT_W-1:0]   a_wdata;
    logic [COEFF_W-1:0] w1_rdata, w2_rdata, b_rdata;
    logic [ACT_W-1:0]   a_rdata;

    // Pixel state
    logic [POS_W-1:0]  r_pos, r_pix_pos;
    logic              r_img_end;
    logic [ACT_W-1:0]  r_a;
    logic              pos_end;

    // MAC pipeline
    logic              r_d1_v, r_d1_pix, r_d2_v, r_d2_pix;
    logic [CNT_W-1:0]  r_d1_y, r_d2_y;
    logic signed [ACC_W-1:0] prod_full;
    logic [ACC_W-1:0]  r_prod;
    logic [ACC_W-1:0]  r_sums [N_NEU];
    logic [ACC_W-1:0]  r_acc;

    // Activation pipeline
    logic [ACC_W:0]    z_ext, mag, mag_s;
    logic [14:0]       t_base, t_next, t_diff;
    logic              r_t_neg, r_t_big;
    logic [14:0]       r_t_base;
    logic [12:0]       r_t_diff;
    logic [16:0]       r_t_frac;
    logic [29:0]       r_t_prod;
    logic [14:0]       mag_o;
    logic [ACT_W-1:0]  tanh_v;
    logic [SCORE_W-1:0] sig_v;
    logic              is_sig;

    // Scores and output
    logic [SCORE_W-1:0] r_score [N_NEU];
    logic [SCORE_W-1:0] r_max;
    logic [NEU_W-1:0]   r_best;
    logic               r_oval;
    t_out_item          r_out;

    logic ld_ok;

    assign is_sig = (i_cmd.layer == OUT_LAY);
    assign ld_ok  = i_cmd.accept && (i_in.neuron_sel < NEU_W'(N_NEU));

    // Load decode and memory addressing
    always_comb begin
        w1_we = ld_ok && (i_in.cmd == CMD_LOAD_W) && (i_in.layer_sel == '0)
              && (i_in.weight_sel < WSEL_W'(IMAGE_PIXELS));
        w2_we = ld_ok && (i_in.cmd == CMD_LOAD_W) && (i_in.layer_sel != '0)
              && (i_in.layer_sel <= OUT_LAY) && (i_in.weight_sel < WSEL_W'(N_NEU));
        b_we  = ld_ok && (i_in.cmd == CMD_LOAD_B) && (i_in.layer_sel <= OUT_LAY);
        a_we  = i_cmd.act_s3 && !is_sig;

        if (w1_we) begin
            w1_addr = W1_AW'(i_in.neuron_sel) * W1_AW'(IMAGE_PIXELS)
                    + W1_AW'(i_in.weight_sel);
        end else begin
            w1_addr = W1_AW'(i_cmd.y) * W1_AW'(IMAGE_PIXELS) + W1_AW'(r_pix_pos);
        end
        if (w2_we) begin
            w2_addr = (W2_AW'(i_in.layer_sel) - W2_AW'(1)) * W2_AW'(N_NEU * N_NEU)
                    + W2_AW'(i_in.neuron_sel) * W2_AW'(N_NEU) + W2_AW'(i_in.weight_sel);
        end else begin
            w2_addr = (W2_AW'(i_cmd.layer) - W2_AW'(1)) * W2_AW'(N_NEU * N_NEU)
                    + W2_AW'(i_cmd.y) * W2_AW'(N_NEU) + W2_AW'(i_cmd.x);
        end
        if (b_we) begin
            b_addr = B_AW'(i_in.layer_sel) * B_AW'(N_NEU) + B_AW'(i_in.neuron_sel);
        end else begin
            b_addr = B_AW'(i_cmd.layer) * B_AW'(N_NEU) + B_AW'(i_cmd.y);
        end
        if (a_we) begin
            a_addr = A_AW'(i_cmd.layer) * A_AW'(N_NEU) + A_AW'(i_cmd.y);
        end else begin
            a_addr = (A_AW'(i_cmd.layer) - A_AW'(1)) * A_AW'(N_NEU) + A_AW'(i_cmd.x);
        end
    end

    mlp_ram #(.WIDTH(COEFF_W), .DEPTH(W1_DEPTH)) u_w1 (
        .i_clk(i_clk), .i_we(w1_we), .i_addr(w1_addr),
        .i_wdata(i_in.coeff), .o_rdata(w1_rdata)
    );

    mlp_ram #(.WIDTH(COEFF_W), .DEPTH(W2_DEPTH)) u_w2 (
        .i_clk(i_clk), .i_we(w2_we), .i_addr(w2_addr),
        .i_wdata(i_in.coeff), .o_rdata(w2_rdata)
    );

    mlp_ram #(.WIDTH(COEFF_W), .DEPTH(B_DEPTH)) u_bias (
        .i_clk(i_clk), .i_we(b_we), .i_addr(b_addr),
        .i_wdata(i_in.coeff), .o_rdata(b_rdata)
    );

    mlp_ram #(.WIDTH(ACT_W), .DEPTH(A_DEPTH)) u_act (
        .i_clk(i_clk), .i_we(a_we), .i_addr(a_addr),
        .i_wdata(a_wdata), .o_rdata(a_rdata)
    );

    // Pixel position; image ends on the flag or the final position
    assign pos_end = i_in.last_pixel || (r_pos == POS_W'(IMAGE_PIXELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.accept && (i_in.cmd == CMD_PIXEL)) begin
            r_pos <= pos_end ? '0 : r_pos + 1'b1;
        end
    end

    // Pixel request capture: activation is (p*257)>>1
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in.cmd == CMD_PIXEL)) begin
            r_a       <= {1'b0, i_in.pixel, i_in.pixel[PIX_W-1:1]};
            r_pix_pos <= r_pos;
            r_img_end <= pos_end;
        end
    end

    // MAC pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
        end else begin
            r_d1_v <= i_cmd.pix_mac || i_cmd.lay_mac;
            r_d2_v <= r_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_pix <= i_cmd.pix_mac;
        r_d1_y   <= i_cmd.y;
        r_d2_pix <= r_d1_pix;
        r_d2_y   <= r_d1_y;
    end

    // Product stage, floor shift to Q.19
    assign prod_full = r_d1_pix ? ($signed(w1_rdata) * $signed(r_a))
                                : ($signed(w2_rdata) * $signed(a_rdata));

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full >>> 8;
    end

    // First-layer sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_sums) begin
            for (int i = 0; i < N_NEU; i++) begin
                r_sums[i] <= '0;
            end
        end else if (r_d2_v && r_d2_pix) begin
            r_sums[r_d2_y] <= sat_acc({r_sums[r_d2_y][ACC_W-1], r_sums[r_d2_y]}
                                    + {r_prod[ACC_W-1], r_prod});
        end
    end

    // Neuron accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sum) begin
            r_acc <= r_sums[i_cmd.y];
        end else if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (i_cmd.bias_add) begin
            r_acc <= sat_acc({r_acc[ACC_W-1], r_acc}
                           + {{10{b_rdata[COEFF_W-1]}}, b_rdata, 7'b0});
        end else if (r_d2_v && !r_d2_pix) begin
            r_acc <= sat_acc({r_acc[ACC_W-1], r_acc} + {r_prod[ACC_W-1], r_prod});
        end
    end

    // Activation stage 1: magnitude, table lookup
    always_comb begin
        z_ext  = {r_acc[ACC_W-1], r_acc};
        mag    = r_acc[ACC_W-1] ? (~z_ext + 1'b1) : z_ext;
        mag_s  = is_sig ? {1'b0, mag[ACC_W:1]} : mag;
        t_base = tanh_tab({1'b0, mag_s[20:17]});
        t_next = tanh_tab({1'b0, mag_s[20:17]} + 5'd1);
        t_diff = t_next - t_base;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_s1) begin
            r_t_neg  <= r_acc[ACC_W-1];
            r_t_big  <= |mag_s[ACC_W:21];
            r_t_base <= t_base;
            r_t_diff <= t_diff[12:0];
            r_t_frac <= mag_s[16:0];
        end
        // stage 2: interpolation product
        r_t_prod <= 30'(r_t_diff) * 30'(r_t_frac);
    end

    // Activation stage 3: finish tanh or sigmoid
    always_comb begin
        mag_o   = r_t_big ? TANH_TOP : (r_t_base + 15'(r_t_prod[29:17]));
        tanh_v  = r_t_neg ? (16'd0 - {1'b0, mag_o}) : {1'b0, mag_o};
        sig_v   = r_t_neg ? (16'd32768 - {1'b0, mag_o}) : (16'd32768 + {1'b0, mag_o});
        a_wdata = tanh_v;
    end

    // Scores and running argmax
    always_ff @(posedge i_clk) begin
        if (i_cmd.act_s3 && is_sig) begin
            r_score[i_cmd.y] <= sig_v;
            if ((i_cmd.y == '0) || (sig_v > r_max)) begin
                r_max  <= sig_v;
                r_best <= i_cmd.y;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_oval <= 1'b1;
        end else if (!i_out_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.class_index <= i_cmd.y;
            r_out.score       <= r_score[i_cmd.y];
            r_out.best_class  <= r_best;
            r_out.last        <= (i_cmd.y == CNT_W'(N_NEU - 1));
        end
    end

    assign o_out_valid = r_oval;
    assign o_out       = r_out;

    // Status
    assign o_st.in_pix   = (i_in.cmd == CMD_PIXEL);
    assign o_st.img_end  = r_img_end;
    assign o_st.out_free = !r_oval || !i_out_stall;

endmodule

// ===== rtl/mlp_digit_classifier_unit.sv =====
// Fixed-point MLP digit classifier. Weight and bias load requests are
// written as they are accepted, without stalling the input. A pixel request
// runs ten multiply-accumulates through the single shared MAC, one per cycle
// as the first-layer weight memory streams out, then lets the MAC pipeline
// drain. The last pixel of an image starts a pass in which each first-layer
// neuron adds its bias and activates, each neuron of the three 10x10 layers
// runs ten MACs, a bias add and a three-stage tanh/sigmoid interpolator, then
// ten scores leave through the output register, one per cycle when not
// stalled. Loaded entries must be written before an image reads them. The
// input stalls while a request is in progress; a finished score may wait
// at the output while the next request is taken.
module mlp_digit_classifier_unit import mlp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_ctrl_cmd  cmd;
    t_dp_status st;

    mlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    mlp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
